>>> design/sma_pkg.sv
// Shared types and constants of the slope moment accumulator.
// Field widths, configuration register indexes and the command and status
// structs that join the controller to the datapath. No dependencies.
package sma_pkg;

  // Input normal components, signed Q1.15.
  localparam int NORM_W     = 16;
  localparam int NZ_W       = 15;
  localparam int FRAC_W     = 16;

  // Configuration registers.
  localparam int SQRT_SPP_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam int RST_SQRT_SPP   = 4;
  localparam int RST_MIN_NORM_Z = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_SQRT_SPP     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_NORMAL_Z = 1'b1;

  // Result fields.
  localparam int SLOPE_W  = 24;
  localparam int MSQ_W    = 30;
  localparam int MCROSS_W = 31;

  // Running sums.
  localparam int SUM_SLOPE_W = 32;
  localparam int SUM_W       = 40;

  // Scaled product of two slope magnitudes, Q15.16.
  localparam int PROD_W = 2 * SLOPE_W - 1 - FRAC_W;

  // Stream payloads.
  localparam int IN_TDATA_W    = 3 * NORM_W;
  localparam int OUT_FIELDS_W  = 2 * SLOPE_W + 2 * MSQ_W + MCROSS_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // What the shared dividers are working on.
  typedef enum logic [1:0] {
    DIV_SLOPE,
    DIV_MEAN_SLOPE,
    DIV_MEAN_SQUARE,
    DIV_MEAN_CROSS
  } div_op_t;

  // Which slope product is formed or accumulated.
  typedef enum logic [1:0] {
    PROD_SQ_X,
    PROD_SQ_Y,
    PROD_CROSS
  } prod_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      div_start;
    logic      div_take;
    div_op_t   div_op;
    logic      mul_en;
    prod_sel_t mul_sel;
    logic      acc_slope;
    logic      acc_en;
    prod_sel_t acc_sel;
    logic      count_inc;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic texel_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

>>> design/sma_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// The dividend is given left aligned and the caller sets the number of
// steps. Depends on nothing else.
module sma_divider #(
  parameter int DVD_W = 40,
  parameter int DSR_W = 15
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DVD_W-1:0]           dividend,
  input  logic [DSR_W-1:0]           divisor,
  input  logic [$clog2(DVD_W+1)-1:0] iters,
  output logic [DVD_W-1:0]           quotient,
  output logic                       busy,
  output logic                       done
);

  localparam int IT_W = $clog2(DVD_W + 1);

  logic [DSR_W-1:0] rem;
  logic [DVD_W-1:0] dq;
  logic [IT_W-1:0]  cnt;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             fits;

  assign trial = {rem, dq[DVD_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == IT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      dq  <= {dq[DVD_W-2:0], fits};
    end
  end

  assign quotient = dq;

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("divider flagged done without finishing a run");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while a division was running");

endmodule

>>> design/sma_datapath.sv
// Datapath: configuration registers, input capture, two dividers, the shared
// slope multiplier, saturating sums, mean results and the output register.
// Depends on sma_pkg and sma_divider.
module sma_datapath
  import sma_pkg::*;
#(
  parameter int MAX_SQRT_SPP = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  output ctrl_stat_t             status,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  localparam int S_W     = $clog2(MAX_SQRT_SPP + 1);
  localparam int CMP_W   = (S_W > SQRT_SPP_W) ? S_W : SQRT_SPP_W;
  localparam int SPP_MAX = MAX_SQRT_SPP * MAX_SQRT_SPP;
  localparam int CNT_W   = $clog2(SPP_MAX + 1);
  localparam int DSR_W   = (CNT_W > NZ_W) ? CNT_W : NZ_W;
  localparam int IT_W    = $clog2(SUM_W + 1);
  localparam int RST_S   = (RST_SQRT_SPP > MAX_SQRT_SPP) ? MAX_SQRT_SPP : RST_SQRT_SPP;

  localparam logic [SUM_W-1:0] SLOPE_POS_LIM = SUM_W'((64'd1 << (SLOPE_W - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] SLOPE_NEG_LIM = SUM_W'(64'd1 << (SLOPE_W - 1));
  localparam logic [SUM_W-1:0] SQ_LIM        = SUM_W'((64'd1 << MSQ_W) - 64'd1);
  localparam logic [SUM_W-1:0] CROSS_POS_LIM = SUM_W'((64'd1 << (MCROSS_W - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] CROSS_NEG_LIM = SUM_W'(64'd1 << (MCROSS_W - 1));

  localparam logic [SUM_SLOPE_W-1:0] SSL_MAX = {1'b0, {(SUM_SLOPE_W-1){1'b1}}};
  localparam logic [SUM_SLOPE_W-1:0] SSL_MIN = {1'b1, {(SUM_SLOPE_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]       SCR_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]       SCR_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  function automatic logic [SUM_W-1:0] cap(input logic [SUM_W-1:0] q,
                                           input logic [SUM_W-1:0] lim);
    return (q > lim) ? lim : q;
  endfunction

  // Quotient magnitude to a saturated signed slope.
  function automatic logic [SLOPE_W-1:0] to_slope(input logic [SUM_W-1:0] q,
                                                  input logic neg);
    logic [SLOPE_W-1:0] m;
    m = SLOPE_W'(cap(q, neg ? SLOPE_NEG_LIM : SLOPE_POS_LIM));
    return neg ? (~m + 1'b1) : m;
  endfunction

  function automatic logic [MCROSS_W-1:0] to_cross(input logic [SUM_W-1:0] q,
                                                   input logic neg);
    logic [MCROSS_W-1:0] m;
    m = MCROSS_W'(cap(q, neg ? CROSS_NEG_LIM : CROSS_POS_LIM));
    return neg ? (~m + 1'b1) : m;
  endfunction

  // Configuration, held in its effective form.
  logic [CNT_W-1:0] spp;
  logic [NZ_W-1:0]  zmin;
  logic [CMP_W-1:0] s_raw;
  logic [CMP_W-1:0] s_eff;
  logic [NZ_W-1:0]  z_raw;

  assign s_raw = CMP_W'(cfg_data[SQRT_SPP_W-1:0]);
  assign s_eff = (s_raw == '0) ? CMP_W'(1) :
                 (s_raw > CMP_W'(MAX_SQRT_SPP)) ? CMP_W'(MAX_SQRT_SPP) : s_raw;
  assign z_raw = cfg_data[NZ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      spp  <= CNT_W'(RST_S * RST_S);
      zmin <= NZ_W'(RST_MIN_NORM_Z);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SQRT_SPP:     spp  <= CNT_W'(s_eff) * CNT_W'(s_eff);
        CFG_MIN_NORMAL_Z: zmin <= (z_raw == '0) ? NZ_W'(1) : z_raw;
        default: ;
      endcase
    end
  end

  // Input capture: component magnitudes and signs, clamped divisor.
  logic [NORM_W-1:0] nx_in, ny_in, nz_in;
  logic [NORM_W-1:0] mag_x, mag_y;
  logic              nx_neg, ny_neg;
  logic [NZ_W-1:0]   nz_eff;

  assign nx_in = in_data[NORM_W-1:0];
  assign ny_in = in_data[2*NORM_W-1:NORM_W];
  assign nz_in = in_data[3*NORM_W-1:2*NORM_W];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      nx_neg <= nx_in[NORM_W-1];
      ny_neg <= ny_in[NORM_W-1];
      mag_x  <= nx_in[NORM_W-1] ? (~nx_in + 1'b1) : nx_in;
      mag_y  <= ny_in[NORM_W-1] ? (~ny_in + 1'b1) : ny_in;
      nz_eff <= (nz_in[NORM_W-1] || (nz_in[NZ_W-1:0] < zmin)) ? zmin : nz_in[NZ_W-1:0];
    end
  end

  // Sums and sample count.
  logic [SUM_SLOPE_W-1:0] sum_slope_x, sum_slope_y;
  logic [SUM_W-1:0]       sum_square_x, sum_square_y, sum_cross;
  logic [CNT_W-1:0]       sample_count;

  logic [SUM_SLOPE_W-1:0] sslx_mag, ssly_mag;
  logic [SUM_W-1:0]       scr_mag;

  assign sslx_mag = sum_slope_x[SUM_SLOPE_W-1] ? (~sum_slope_x + 1'b1) : sum_slope_x;
  assign ssly_mag = sum_slope_y[SUM_SLOPE_W-1] ? (~sum_slope_y + 1'b1) : sum_slope_y;
  assign scr_mag  = sum_cross[SUM_W-1] ? (~sum_cross + 1'b1) : sum_cross;

  // Two divider lanes sharing one sequence of operations.
  logic [SUM_W-1:0] dvd_a, dvd_b, q_a, q_b;
  logic [DSR_W-1:0] divisor;
  logic [IT_W-1:0]  iters;
  logic             busy_a, busy_b, done_a, done_b;

  always_comb begin
    unique case (cmd.div_op)
      DIV_SLOPE: begin
        dvd_a = SUM_W'(mag_x) << (SUM_W - NORM_W);
        dvd_b = SUM_W'(mag_y) << (SUM_W - NORM_W);
        iters = IT_W'(NORM_W + FRAC_W);
      end
      DIV_MEAN_SLOPE: begin
        dvd_a = SUM_W'(sslx_mag) << (SUM_W - SUM_SLOPE_W);
        dvd_b = SUM_W'(ssly_mag) << (SUM_W - SUM_SLOPE_W);
        iters = IT_W'(SUM_SLOPE_W);
      end
      DIV_MEAN_SQUARE: begin
        dvd_a = sum_square_x;
        dvd_b = sum_square_y;
        iters = IT_W'(SUM_W);
      end
      DIV_MEAN_CROSS: begin
        dvd_a = scr_mag;
        dvd_b = scr_mag;
        iters = IT_W'(SUM_W);
      end
      default: begin
        dvd_a = '0;
        dvd_b = '0;
        iters = IT_W'(SUM_W);
      end
    endcase
    divisor = (cmd.div_op == DIV_SLOPE) ? DSR_W'(nz_eff) : DSR_W'(spp);
  end

  sma_divider #(.DVD_W(SUM_W), .DSR_W(DSR_W)) u_div_a (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd_a),
    .divisor  (divisor),
    .iters    (iters),
    .quotient (q_a),
    .busy     (busy_a),
    .done     (done_a)
  );

  sma_divider #(.DVD_W(SUM_W), .DSR_W(DSR_W)) u_div_b (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd_b),
    .divisor  (divisor),
    .iters    (iters),
    .quotient (q_b),
    .busy     (busy_b),
    .done     (done_b)
  );

  // Slopes and the mean results, taken from the divider quotients.
  logic [SLOPE_W-1:0]  slope_x, slope_y;
  logic [SLOPE_W-1:0]  mean_slope_x, mean_slope_y;
  logic [MSQ_W-1:0]    mean_square_x, mean_square_y;
  logic [MCROSS_W-1:0] mean_cross;

  always_ff @(posedge clk) begin
    if (cmd.div_take) begin
      unique case (cmd.div_op)
        DIV_SLOPE: begin
          // A positive normal component gives a negative slope.
          slope_x <= to_slope(q_a, !nx_neg);
          slope_y <= to_slope(q_b, !ny_neg);
        end
        DIV_MEAN_SLOPE: begin
          mean_slope_x <= to_slope(q_a, sum_slope_x[SUM_SLOPE_W-1]);
          mean_slope_y <= to_slope(q_b, sum_slope_y[SUM_SLOPE_W-1]);
        end
        DIV_MEAN_SQUARE: begin
          mean_square_x <= MSQ_W'(cap(q_a, SQ_LIM));
          mean_square_y <= MSQ_W'(cap(q_b, SQ_LIM));
        end
        DIV_MEAN_CROSS: mean_cross <= to_cross(q_a, sum_cross[SUM_W-1]);
        default: ;
      endcase
    end
  end

  // Shared multiplier on slope magnitudes; the product is scaled back to
  // Q.16 on its magnitude, so it truncates toward zero.
  logic [SLOPE_W-1:0]   abs_x, abs_y, mul_a, mul_b;
  logic [2*SLOPE_W-1:0] mul_full;
  logic                 mul_neg;
  logic [PROD_W-1:0]    prod;
  logic                 prod_neg;

  assign abs_x = slope_x[SLOPE_W-1] ? (~slope_x + 1'b1) : slope_x;
  assign abs_y = slope_y[SLOPE_W-1] ? (~slope_y + 1'b1) : slope_y;

  always_comb begin
    unique case (cmd.mul_sel)
      PROD_SQ_X: begin
        mul_a   = abs_x;
        mul_b   = abs_x;
        mul_neg = 1'b0;
      end
      PROD_SQ_Y: begin
        mul_a   = abs_y;
        mul_b   = abs_y;
        mul_neg = 1'b0;
      end
      PROD_CROSS: begin
        mul_a   = abs_x;
        mul_b   = abs_y;
        mul_neg = slope_x[SLOPE_W-1] ^ slope_y[SLOPE_W-1];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod     <= mul_full[2*SLOPE_W-2:FRAC_W];
      prod_neg <= mul_neg;
    end
  end

  // Saturating additions.
  logic [SUM_SLOPE_W:0] slx_add, sly_add;
  logic [SUM_W:0]       sqx_add, sqy_add, scr_add;
  logic [PROD_W:0]      prod_s;

  assign slx_add = {sum_slope_x[SUM_SLOPE_W-1], sum_slope_x}
                 + {{(SUM_SLOPE_W + 1 - SLOPE_W){slope_x[SLOPE_W-1]}}, slope_x};
  assign sly_add = {sum_slope_y[SUM_SLOPE_W-1], sum_slope_y}
                 + {{(SUM_SLOPE_W + 1 - SLOPE_W){slope_y[SLOPE_W-1]}}, slope_y};
  assign sqx_add = {1'b0, sum_square_x} + (SUM_W + 1)'(prod);
  assign sqy_add = {1'b0, sum_square_y} + (SUM_W + 1)'(prod);
  assign prod_s  = prod_neg ? (~{1'b0, prod} + 1'b1) : {1'b0, prod};
  assign scr_add = {sum_cross[SUM_W-1], sum_cross}
                 + {{(SUM_W - PROD_W){prod_s[PROD_W]}}, prod_s};

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      sum_slope_x  <= '0;
      sum_slope_y  <= '0;
      sum_square_x <= '0;
      sum_square_y <= '0;
      sum_cross    <= '0;
      sample_count <= '0;
    end else begin
      if (cmd.acc_slope) begin
        if (slx_add[SUM_SLOPE_W] != slx_add[SUM_SLOPE_W-1]) begin
          sum_slope_x <= slx_add[SUM_SLOPE_W] ? SSL_MIN : SSL_MAX;
        end else begin
          sum_slope_x <= slx_add[SUM_SLOPE_W-1:0];
        end
        if (sly_add[SUM_SLOPE_W] != sly_add[SUM_SLOPE_W-1]) begin
          sum_slope_y <= sly_add[SUM_SLOPE_W] ? SSL_MIN : SSL_MAX;
        end else begin
          sum_slope_y <= sly_add[SUM_SLOPE_W-1:0];
        end
      end
      if (cmd.acc_en) begin
        unique case (cmd.acc_sel)
          PROD_SQ_X: sum_square_x <= sqx_add[SUM_W] ? '1 : sqx_add[SUM_W-1:0];
          PROD_SQ_Y: sum_square_y <= sqy_add[SUM_W] ? '1 : sqy_add[SUM_W-1:0];
          PROD_CROSS: begin
            if (scr_add[SUM_W] != scr_add[SUM_W-1]) begin
              sum_cross <= scr_add[SUM_W] ? SCR_MIN : SCR_MAX;
            end else begin
              sum_cross <= scr_add[SUM_W-1:0];
            end
          end
          default: ;
        endcase
      end
      if (cmd.count_inc) begin
        sample_count <= sample_count + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {(OUT_TDATA_W - OUT_FIELDS_W)'(0), mean_cross, mean_square_y,
                   mean_square_x, mean_slope_y, mean_slope_x};
    end
  end

  assign status.div_done   = done_a;
  assign status.texel_done = sample_count >= spp;
  assign status.out_free   = !out_valid || out_ready;

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    (busy_a == busy_b) && (done_a == done_b))
    else $error("divider lanes out of step");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(SPP_MAX))
    else $error("sample count beyond the largest texel");

  a_texel_closes: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid && (sample_count == '0) && (sum_cross == '0)
                     && (sum_slope_x == '0))
    else $error("texel result loaded without clearing the sums");

endmodule

>>> design/sma_ctrl.sv
// Controller state machine: sequences input capture, the slope divisions,
// the three slope products and, at the end of a texel, the mean divisions.
// Depends on sma_pkg.
module sma_ctrl
  import sma_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_valid,
  output logic       s_ready,
  input  ctrl_stat_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    IDLE,
    DIV_GO,
    DIV_WAIT,
    MUL_X,
    MUL_Y,
    MUL_C,
    ACC_C,
    CHECK,
    OUT
  } state_t;

  state_t  state, state_next;
  div_op_t op, op_next;

  always_comb begin
    state_next    = state;
    op_next       = op;
    cmd           = '0;
    cmd.div_op    = op;
    cmd.mul_sel   = PROD_SQ_X;
    cmd.acc_sel   = PROD_SQ_X;
    unique case (state)
      IDLE: begin
        if (s_valid && s_ready) begin
          cmd.load_in = 1'b1;
          op_next     = DIV_SLOPE;
          state_next  = DIV_GO;
        end
      end
      DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = DIV_WAIT;
      end
      DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_take = 1'b1;
          unique case (op)
            DIV_SLOPE:       state_next = MUL_X;
            DIV_MEAN_SLOPE: begin
              op_next    = DIV_MEAN_SQUARE;
              state_next = DIV_GO;
            end
            DIV_MEAN_SQUARE: begin
              op_next    = DIV_MEAN_CROSS;
              state_next = DIV_GO;
            end
            DIV_MEAN_CROSS:  state_next = OUT;
            default:         state_next = IDLE;
          endcase
        end
      end
      MUL_X: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = PROD_SQ_X;
        cmd.acc_slope = 1'b1;
        state_next    = MUL_Y;
      end
      MUL_Y: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = PROD_SQ_Y;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = PROD_SQ_X;
        state_next  = MUL_C;
      end
      MUL_C: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = PROD_CROSS;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = PROD_SQ_Y;
        state_next  = ACC_C;
      end
      ACC_C: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_sel   = PROD_CROSS;
        cmd.count_inc = 1'b1;
        state_next    = CHECK;
      end
      CHECK: begin
        if (status.texel_done) begin
          op_next    = DIV_MEAN_SLOPE;
          state_next = DIV_GO;
        end else begin
          state_next = IDLE;
        end
      end
      OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      op      <= DIV_SLOPE;
      s_ready <= 1'b1;
    end else begin
      state   <= state_next;
      op      <= op_next;
      s_ready <= (state_next == IDLE);
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over an untaken beat");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> !s_ready && (state == DIV_GO))
    else $error("input still open after a beat was accepted");

endmodule

>>> design/slope_moment_accumulator_top.sv
// Slope moment accumulator: per-sample slopes from surface normals, running
// moment sums and one mean result beat per texel.
// Depends on sma_pkg, sma_ctrl, sma_datapath and sma_divider.
//
// Samples: a new sample is taken only once the last one has been fully
// processed; the two slope divisions run side by side in a pair of
// one-bit-per-cycle dividers, then one shared multiplier forms the three products.
// Texel close: the sample that closes a texel adds three mean division
// rounds before its result beat appears. Input stays open while an earlier
// result waits at the output.
// Reset: synchronous, active high; sums, count and both configuration
// registers return to their reset values at once, with no clearing pass.
module slope_moment_accumulator_top
  import sma_pkg::*;
#(
  parameter int MAX_SQRT_SPP = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // Sample input.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // From bit 0: normal_x[15:0], normal_y[15:0], normal_z[15:0].
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Texel result output.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // From bit 0: mean_slope_x[23:0], mean_slope_y[23:0], mean_square_x[29:0],
  // mean_square_y[29:0], mean_cross[30:0], then zero padding to 144 bits.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration writes: index 0 is sqrt_spp, index 1 is min_normal_z.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t status;

  // The controller takes one sample at a time and walks it through the
  // division, product and accumulation steps; at the end of a texel it runs
  // the mean divisions and hands the result to the output register.
  sma_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  // The datapath holds the configuration, sums, dividers, multiplier and
  // the output register, which lets a result wait while input goes on.
  sma_datapath #(.MAX_SQRT_SPP(MAX_SQRT_SPP)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

>>> tb/sv/sma_moment_checker.sv
`timescale 1ns / 100ps
// Checker for the slope moment accumulator: predicts the mean result of each
// texel from the accepted sample beats and compares the result beats with it.
// Depends on sma_pkg for field widths and configuration register indexes.
module sma_moment_checker
  import sma_pkg::*;
#(
  parameter int MAX_SQRT_SPP = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     pending,
  output int                     fails
);

  localparam longint SLOPE_HI = (longint'(1) << (SLOPE_W - 1)) - 1;
  localparam longint SLOPE_LO = -(longint'(1) << (SLOPE_W - 1));
  localparam longint SUM_S_HI = (longint'(1) << (SUM_SLOPE_W - 1)) - 1;
  localparam longint SUM_S_LO = -(longint'(1) << (SUM_SLOPE_W - 1));
  localparam longint SUM_U_HI = (longint'(1) << SUM_W) - 1;
  localparam longint SUM_XY_HI = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_XY_LO = -(longint'(1) << (SUM_W - 1));
  localparam longint SQ_HI = (longint'(1) << MSQ_W) - 1;
  localparam longint XY_HI = (longint'(1) << (MCROSS_W - 1)) - 1;
  localparam longint XY_LO = -(longint'(1) << (MCROSS_W - 1));

  // Bit offsets of the result fields within the output tdata.
  localparam int OFF_MY = SLOPE_W;
  localparam int OFF_XX = 2 * SLOPE_W;
  localparam int OFF_YY = OFF_XX + MSQ_W;
  localparam int OFF_XY = OFF_YY + MSQ_W;

  typedef struct {
    logic signed [SLOPE_W-1:0]  mean_sx;
    logic signed [SLOPE_W-1:0]  mean_sy;
    logic        [MSQ_W-1:0]    mean_xx;
    logic        [MSQ_W-1:0]    mean_yy;
    logic signed [MCROSS_W-1:0] mean_xy;
  } texel_means_t;

  texel_means_t texel_q[$];

  logic [SQRT_SPP_W-1:0] texel_side;
  logic [NZ_W-1:0]       z_floor;
  longint acc_x, acc_y, acc_xx, acc_yy, acc_xy;
  longint samples;

  initial fails = 0;

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Slope -n/nz in Q8.16, quotient truncated toward zero, then saturated.
  function automatic longint slope_q816(input longint n, input longint nz);
    longint q;
    q = (n * 65536) / nz;
    return sat(-q, SLOPE_LO, SLOPE_HI);
  endfunction

  // Product of two Q8.16 slopes brought back to Q.16, truncating the magnitude.
  function automatic longint scaled_product(input longint a, input longint b);
    longint p, mag;
    p = a * b;
    mag = (p < 0) ? -p : p;
    mag = mag >> FRAC_W;
    return (p < 0) ? -mag : mag;
  endfunction

  function automatic void clear_sums();
    acc_x = 0;
    acc_y = 0;
    acc_xx = 0;
    acc_yy = 0;
    acc_xy = 0;
    samples = 0;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] seen_v);
    if (want_v !== seen_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, seen_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    logic signed [NORM_W-1:0] cx, cy, cz;
    longint nz, zlim, side, area, sx, sy;
    texel_means_t made, want, got;
    if (rst) begin
      texel_side = SQRT_SPP_W'(RST_SQRT_SPP);
      z_floor = NZ_W'(RST_MIN_NORM_Z);
      clear_sums();
      texel_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SQRT_SPP) texel_side = cfg_data[SQRT_SPP_W-1:0];
        else if (cfg_index == CFG_MIN_NORMAL_Z) z_floor = cfg_data[NZ_W-1:0];
      end

      if (s_axis_tvalid && s_axis_tready) begin
        cx = s_axis_tdata[NORM_W-1:0];
        cy = s_axis_tdata[2*NORM_W-1:NORM_W];
        cz = s_axis_tdata[3*NORM_W-1:2*NORM_W];
        zlim = longint'(z_floor);
        if (zlim == 0) zlim = 1;
        side = longint'(texel_side);
        if (side == 0) side = 1;
        if (side > MAX_SQRT_SPP) side = MAX_SQRT_SPP;
        area = side * side;
        nz = longint'(cz);
        if (nz < zlim) nz = zlim;
        sx = slope_q816(longint'(cx), nz);
        sy = slope_q816(longint'(cy), nz);
        acc_x = sat(acc_x + sx, SUM_S_LO, SUM_S_HI);
        acc_y = sat(acc_y + sy, SUM_S_LO, SUM_S_HI);
        acc_xx = sat(acc_xx + scaled_product(sx, sx), 0, SUM_U_HI);
        acc_yy = sat(acc_yy + scaled_product(sy, sy), 0, SUM_U_HI);
        acc_xy = sat(acc_xy + scaled_product(sx, sy), SUM_XY_LO, SUM_XY_HI);
        samples++;
        // A lowered sample count can leave the texel already over full.
        if (samples >= area) begin
          made.mean_sx = SLOPE_W'(sat(acc_x / area, SLOPE_LO, SLOPE_HI));
          made.mean_sy = SLOPE_W'(sat(acc_y / area, SLOPE_LO, SLOPE_HI));
          made.mean_xx = MSQ_W'(sat(acc_xx / area, 0, SQ_HI));
          made.mean_yy = MSQ_W'(sat(acc_yy / area, 0, SQ_HI));
          made.mean_xy = MCROSS_W'(sat(acc_xy / area, XY_LO, XY_HI));
          texel_q.push_back(made);
          clear_sums();
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (texel_q.size() == 0) begin
          $display("%0t: result beat with no texel outstanding, tdata %h",
                   $time, m_axis_tdata);
          fails++;
        end else begin
          want = texel_q.pop_front();
          got.mean_sx = m_axis_tdata[SLOPE_W-1:0];
          got.mean_sy = m_axis_tdata[OFF_MY +: SLOPE_W];
          got.mean_xx = m_axis_tdata[OFF_XX +: MSQ_W];
          got.mean_yy = m_axis_tdata[OFF_YY +: MSQ_W];
          got.mean_xy = m_axis_tdata[OFF_XY +: MCROSS_W];
          check_field("mean_slope_x", 32'(want.mean_sx), 32'(got.mean_sx));
          check_field("mean_slope_y", 32'(want.mean_sy), 32'(got.mean_sy));
          check_field("mean_square_x", 32'(want.mean_xx), 32'(got.mean_xx));
          check_field("mean_square_y", 32'(want.mean_yy), 32'(got.mean_yy));
          check_field("mean_cross", 32'(want.mean_xy), 32'(got.mean_xy));
        end
      end
    end
    pending <= texel_q.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the slope moment accumulator testbench: clock, reset, sample and
// configuration stimulus, result back-pressure and the verdict.
// Depends on sma_pkg, slope_moment_accumulator_top and sma_moment_checker.
module tb;
  import sma_pkg::*;

  localparam int MAX_SQRT_SPP = 16;
  localparam int RANDOM_ITEMS = 1200;
  // Quiet cycles kept after the last result; this many guarantee that the
  // block has finished all work in hand before the next phase begins.
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // From bit 0: normal_x, normal_y, normal_z, 16 bits each.
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  // From bit 0: mean_slope_x, mean_slope_y, mean_square_x, mean_square_y,
  // mean_cross, then zero padding.
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_SQRT_SPP;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int pending;
  int fails;
  int cycles = 0;
  int hold = 0;
  // When set, neither side idles: used for whole phases now and then and for
  // the closing stretch of the run.
  bit calm = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  slope_moment_accumulator_top #(
    .MAX_SQRT_SPP(MAX_SQRT_SPP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  sma_moment_checker #(
    .MAX_SQRT_SPP(MAX_SQRT_SPP)
  ) moment_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .fails        (fails)
  );

  // Watchdog: a run that hangs anywhere ends here as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side back-pressure. The ready line drops for bursts of random length
  // at random moments, so that stalls catch result beats whenever the
  // block happens to offer one.
  always @(posedge clk) begin
    if (rst || calm) begin
      m_axis_tready <= 1'b1;
      hold <= 0;
    end else if (hold > 1) begin
      hold <= hold - 1;
    end else if (hold == 1) begin
      hold <= 0;
      m_axis_tready <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      hold <= $urandom_range(1, 12);
      m_axis_tready <= 1'b0;
    end
  end

  // Offers one sample beat and returns at the edge where it is taken. Valid
  // stays high afterwards, so a following call can present the next beat at
  // once; any caller that lets time pass first must lower it. Before the beat
  // the sender may idle for a few bursts, which spreads its gaps across the
  // whole of the block's sample processing.
  task automatic send_normal(input logic signed [NORM_W-1:0] nx,
                             input logic signed [NORM_W-1:0] ny,
                             input logic signed [NORM_W-1:0] nz);
    int bursts;
    if (!calm && $urandom_range(0, 2) == 0) begin
      bursts = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (bursts) repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {nz, ny, nx};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Waits until every predicted texel has come out and the block has had
  // time to finish any sample it was still working on.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers are written on back-to-back edges; only called while idle.
  task automatic write_config(input int side, input int zfloor);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SQRT_SPP;
    cfg_data <= CFG_DATA_W'(side);
    @(posedge clk);
    cfg_index <= CFG_MIN_NORMAL_Z;
    cfg_data <= CFG_DATA_W'(zfloor);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly plausible unit normals facing up, with some grazing normals that
  // drive the slopes into saturation, some with zero or negative z, and some
  // with every field fully random.
  task automatic random_normal(output logic [NORM_W-1:0] nx,
                               output logic [NORM_W-1:0] ny,
                               output logic [NORM_W-1:0] nz);
    int kind, z;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      z = $urandom_range(8192, 32767);
      nz = NORM_W'(z);
      nx = NORM_W'(int'($urandom_range(0, 2 * z)) - z);
      ny = NORM_W'(int'($urandom_range(0, 2 * z)) - z);
    end else if (kind == 6) begin
      nz = NORM_W'($urandom_range(0, 255));
      nx = NORM_W'($urandom);
      ny = NORM_W'($urandom);
    end else if (kind == 7) begin
      nz = NORM_W'(-int'($urandom_range(0, 32768)));
      nx = NORM_W'($urandom);
      ny = NORM_W'($urandom);
    end else begin
      nx = NORM_W'($urandom);
      ny = NORM_W'($urandom);
      nz = NORM_W'($urandom);
    end
  endtask

  initial begin
    int sent, phase, side, zfloor, area, count, pick;
    logic [NORM_W-1:0] nx, ny, nz;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One sample per texel, so every beat shows its own slopes. The smallest
    // z floor lets a z of one through, which pins both slopes at their limits
    // and saturates the mean squares and the mean cross product.
    write_config(1, 1);
    send_normal(0, 0, 32767);
    send_normal(32767, 32767, 32767);
    send_normal(-32768, -32768, 32767);
    send_normal(32767, -32768, 1);
    send_normal(-32768, 32767, 0);
    send_normal(100, -100, -32768);
    send_normal(-1, 1, 32767);
    send_normal(32767, 32767, 1);
    settle();

    // Zero in both registers: each must behave as one.
    write_config(0, 0);
    send_normal(32767, -32768, 0);
    send_normal(1000, -1000, -1);
    send_normal(5, 5, 0);
    settle();

    // Largest z floor, so every z is lifted to it; four samples per texel.
    write_config(2, 32767);
    send_normal(32767, -32768, 100);
    send_normal(-32768, 32767, 32767);
    send_normal(12345, -23456, -5);
    send_normal(-7, 7, 20000);
    settle();

    // Ten samples into a sixteen sample texel, then the texel is shrunk to
    // four: the next sample must close it although the count is already over.
    write_config(4, 64);
    for (int k = 0; k < 10; k++) send_normal(NORM_W'(k * 3000), NORM_W'(-k * 2100), 30000);
    settle();
    write_config(2, 64);
    send_normal(-2000, 4000, 20000);
    settle();

    // Random phases: each picks a texel size and z floor, then sends one or more
    // whole texels plus a partial one that the next phase inherits. Two
    // phases use the largest texel, one of them through a register value
    // beyond the maximum.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 2) side = 31;
      else if (phase == 9) side = MAX_SQRT_SPP;
      else begin
        pick = $urandom_range(0, 15);
        if (pick == 0) side = 0;
        else if (pick == 1) side = $urandom_range(5, 8);
        else side = $urandom_range(1, 4);
      end

      pick = $urandom_range(0, 7);
      if (pick == 0) zfloor = 0;
      else if (pick == 1) zfloor = 1;
      else if (pick == 2) zfloor = 32767;
      else if (pick == 3) zfloor = $urandom_range(1, 32767);
      else if (pick < 6) zfloor = $urandom_range(1, 1024);
      else zfloor = 64;

      area = (side == 0) ? 1 : (side > MAX_SQRT_SPP ? MAX_SQRT_SPP : side);
      area = area * area;
      if (area > 64) count = area + $urandom_range(0, 20);
      else count = area * $urandom_range(1, 3) + $urandom_range(0, area - 1);

      // Any phase that reaches into the closing stretch runs without idling.
      if (sent + count > RANDOM_ITEMS - 150) calm <= 1'b1;
      else calm <= ($urandom_range(0, 4) == 0);

      write_config(side, zfloor);
      repeat (count) begin
        random_normal(nx, ny, nz);
        send_normal(nx, ny, nz);
      end
      sent += count;
      phase++;
      settle();
    end

    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
design/sma_pkg.sv
design/sma_divider.sv
design/sma_datapath.sv
design/sma_ctrl.sv
design/slope_moment_accumulator_top.sv
tb/sv/sma_moment_checker.sv
tb/sv/tb.sv
